### hdl/sdp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the symmetric diagonal pivot core.
// No dependencies; every other file depends on this package.
package sdp_pkg;

    localparam int CMD_W         = 2;
    localparam int IDX_W         = 6;
    localparam int ELEM_W        = 64;
    localparam int SIZE_W        = 7;
    localparam int DEF_MAX_ORDER = 64;
    localparam int SIZE_RESET    = 64;

    // request opcodes
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 2'd0,
        CMD_RUN       = 2'd1,
        CMD_READ_EL   = 2'd2,
        CMD_READ_PERM = 2'd3
    } t_cmd;

    // matrix store operations
    typedef enum logic [2:0] {
        MAT_NOP     = 3'd0,
        MAT_HOST_WR = 3'd1,
        MAT_HOST_RD = 3'd2,
        MAT_DIAG_RD = 3'd3,
        MAT_SW_RD_A = 3'd4,
        MAT_SW_RD_B = 3'd5,
        MAT_SW_WR_A = 3'd6,
        MAT_SW_WR_B = 3'd7
    } t_mat_op;

    // permutation table operations
    typedef enum logic [2:0] {
        PERM_NOP     = 3'd0,
        PERM_HOST_RD = 3'd1,
        PERM_SW_RD   = 3'd2,
        PERM_SW_WR_I = 3'd3,
        PERM_SW_WR_P = 3'd4,
        PERM_REV_RD  = 3'd5
    } t_perm_op;

    typedef enum logic [1:0] {
        RES_MAT  = 2'd0,
        RES_PERM = 2'd1,
        RES_DONE = 2'd2
    } t_res_kind;

    // controller -> datapath command word
    typedef struct packed {
        t_mat_op   mat_op;
        logic      col_phase;
        logic      scan_init;
        logic      scan_cmp;
        t_perm_op  perm_op;
        logic      rev_wr;
        t_res_kind res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic signed [ELEM_W-1:0] read_bits;
        logic [IDX_W-1:0]         forward_entry;
        logic [IDX_W-1:0]         reverse_entry;
        logic                     run_done;
    } t_result;

endpackage

### hdl/sdp_if.sv
`timescale 1ns / 1ps
// Channel interfaces: request, response and size configuration.
// Depends on sdp_pkg for field widths.
interface sdp_in_if;
    logic                             valid;
    logic                             ready;
    logic [sdp_pkg::CMD_W-1:0]        cmd;
    logic [sdp_pkg::IDX_W-1:0]        row_index;
    logic [sdp_pkg::IDX_W-1:0]        col_index;
    logic signed [sdp_pkg::ELEM_W-1:0] element_bits;

    modport source (output valid, cmd, row_index, col_index, element_bits, input ready);
    modport sink   (input valid, cmd, row_index, col_index, element_bits, output ready);
endinterface

interface sdp_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [sdp_pkg::ELEM_W-1:0] read_bits;
    logic [sdp_pkg::IDX_W-1:0]        forward_entry;
    logic [sdp_pkg::IDX_W-1:0]        reverse_entry;
    logic                             run_done;

    modport source (output valid, read_bits, forward_entry, reverse_entry, run_done,
                    input ready);
    modport sink   (input valid, read_bits, forward_entry, reverse_entry, run_done,
                    output ready);
endinterface

interface sdp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [sdp_pkg::SIZE_W-1:0] matrix_size;

    modport source (output valid, matrix_size, input ready);
    modport sink   (input valid, matrix_size, output ready);
endinterface

### hdl/sdp_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the pivot core: request decode, pivot loops, response timing.
// Depends on sdp_pkg; drives sdp_datapath through t_dp_cmd.
module sdp_ctrl #(
    parameter int  MAX_ORDER = sdp_pkg::DEF_MAX_ORDER,
    localparam int NW        = $clog2(MAX_ORDER + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  sdp_pkg::t_cmd    i_req_cmd,
    input  logic [NW-1:0]    i_size,
    input  logic             i_out_free,
    output logic             o_req_ready,
    output logic             o_out_load,
    output sdp_pkg::t_dp_cmd o_dp_cmd,
    output logic [NW-1:0]    o_pos_i,
    output logic [NW-1:0]    o_pos_j
);
    import sdp_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE     = 14'h0001,
        S_RESP     = 14'h0002,
        S_PIV_CHK  = 14'h0004,
        S_SCAN     = 14'h0008,
        S_SCAN_END = 14'h0010,
        S_SW_RA    = 14'h0020,
        S_SW_RB    = 14'h0040,
        S_SW_WA    = 14'h0080,
        S_SW_WB    = 14'h0100,
        S_PERM_RD  = 14'h0200,
        S_PERM_WI  = 14'h0400,
        S_PERM_WP  = 14'h0800,
        S_REV      = 14'h1000,
        S_REV_END  = 14'h2000
    } t_state;

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [NW-1:0] r_i, n_i;
    logic [NW-1:0] r_j, n_j;
    logic          r_col, n_col;
    logic [NW-1:0] w_last;
    logic          w_last_j;

    assign w_last   = i_size - NW'(1);
    assign w_last_j = (r_j == w_last);
    assign o_pos_i  = r_i;
    assign o_pos_j  = r_j;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_i         = r_i;
        n_j         = r_j;
        n_col       = r_col;
        o_req_ready = 1'b0;
        o_out_load  = 1'b0;
        o_dp_cmd.mat_op    = MAT_NOP;
        o_dp_cmd.col_phase = r_col;
        o_dp_cmd.scan_init = 1'b0;
        o_dp_cmd.scan_cmp  = 1'b0;
        o_dp_cmd.perm_op   = PERM_NOP;
        o_dp_cmd.rev_wr    = 1'b0;
        o_dp_cmd.res_kind  = RES_MAT;

        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_cmd = i_req_cmd;
                    case (i_req_cmd)
                        CMD_WRITE: begin
                            o_dp_cmd.mat_op = MAT_HOST_WR;
                        end
                        CMD_RUN: begin
                            n_i     = '0;
                            n_state = S_PIV_CHK;
                        end
                        CMD_READ_EL: begin
                            o_dp_cmd.mat_op = MAT_HOST_RD;
                            n_state         = S_RESP;
                        end
                        default: begin
                            o_dp_cmd.perm_op = PERM_HOST_RD;
                            n_state          = S_RESP;
                        end
                    endcase
                end
            end
            S_PIV_CHK: begin
                if (r_i < w_last) begin
                    n_j     = r_i;
                    n_state = S_SCAN;
                end else begin
                    n_j     = '0;
                    n_state = S_REV;
                end
            end
            S_SCAN: begin
                // compare acts on the registered diagonal read from the cycle before
                o_dp_cmd.mat_op    = MAT_DIAG_RD;
                o_dp_cmd.scan_init = (r_j == r_i);
                o_dp_cmd.scan_cmp  = (r_j != r_i);
                if (w_last_j) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_j = r_j + NW'(1);
                end
            end
            S_SCAN_END: begin
                o_dp_cmd.scan_cmp = 1'b1;
                n_j     = '0;
                n_col   = 1'b0;
                n_state = S_SW_RA;
            end
            S_SW_RA: begin
                o_dp_cmd.mat_op = MAT_SW_RD_A;
                n_state         = S_SW_RB;
            end
            S_SW_RB: begin
                o_dp_cmd.mat_op = MAT_SW_RD_B;
                n_state         = S_SW_WA;
            end
            S_SW_WA: begin
                o_dp_cmd.mat_op = MAT_SW_WR_A;
                n_state         = S_SW_WB;
            end
            S_SW_WB: begin
                o_dp_cmd.mat_op = MAT_SW_WR_B;
                if (w_last_j) begin
                    n_j = '0;
                    if (r_col) begin
                        n_col   = 1'b0;
                        n_state = S_PERM_RD;
                    end else begin
                        n_col   = 1'b1;
                        n_state = S_SW_RA;
                    end
                end else begin
                    n_j     = r_j + NW'(1);
                    n_state = S_SW_RA;
                end
            end
            S_PERM_RD: begin
                o_dp_cmd.perm_op = PERM_SW_RD;
                n_state          = S_PERM_WI;
            end
            S_PERM_WI: begin
                o_dp_cmd.perm_op = PERM_SW_WR_I;
                n_state          = S_PERM_WP;
            end
            S_PERM_WP: begin
                o_dp_cmd.perm_op = PERM_SW_WR_P;
                n_i              = r_i + NW'(1);
                n_state          = S_PIV_CHK;
            end
            S_REV: begin
                // read forward entry j, write reverse entry for j-1
                o_dp_cmd.perm_op = PERM_REV_RD;
                o_dp_cmd.rev_wr  = (r_j != '0);
                if (w_last_j) begin
                    n_state = S_REV_END;
                end else begin
                    n_j = r_j + NW'(1);
                end
            end
            S_REV_END: begin
                o_dp_cmd.rev_wr = 1'b1;
                n_state         = S_RESP;
            end
            S_RESP: begin
                case (r_cmd)
                    CMD_RUN:     o_dp_cmd.res_kind = RES_DONE;
                    CMD_READ_EL: o_dp_cmd.res_kind = RES_MAT;
                    default:     o_dp_cmd.res_kind = RES_PERM;
                endcase
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= CMD_WRITE;
            r_i     <= '0;
            r_j     <= '0;
            r_col   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_i     <= n_i;
            r_j     <= n_j;
            r_col   <= n_col;
        end
    end

endmodule

### hdl/sdp_datapath.sv
`timescale 1ns / 1ps
// Datapath: matrix store, permutation tables, pivot search and result mux.
// Depends on sdp_pkg; commanded by sdp_ctrl.
module sdp_datapath #(
    parameter int  MAX_ORDER = sdp_pkg::DEF_MAX_ORDER,
    localparam int NW        = $clog2(MAX_ORDER + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sdp_pkg::t_dp_cmd                  i_cmd,
    input  logic [NW-1:0]                     i_pos_i,
    input  logic [NW-1:0]                     i_pos_j,
    input  logic [sdp_pkg::IDX_W-1:0]         i_row,
    input  logic [sdp_pkg::IDX_W-1:0]         i_col,
    input  logic signed [sdp_pkg::ELEM_W-1:0] i_bits,
    output sdp_pkg::t_result                  o_result
);
    import sdp_pkg::*;

    localparam int AW        = $clog2(MAX_ORDER);
    localparam int MEM_DEPTH = 1 << (2 * AW);

    // matrix store, row-major by {row, col}
    logic [ELEM_W-1:0] r_mat [MEM_DEPTH];
    logic [ELEM_W-1:0] r_mat_q;
    logic [ELEM_W-1:0] r_hold;
    logic [2*AW-1:0]   w_mat_addr;
    logic              w_mat_we;
    logic              w_mat_re;
    logic [ELEM_W-1:0] w_mat_wd;

    logic [AW-1:0]     w_pi, w_pj, w_row, w_col;
    logic              w_row_ok, w_col_ok;
    logic [2*AW-1:0]   w_addr_a, w_addr_b;

    logic [ELEM_W-2:0] r_best;
    logic [ELEM_W-2:0] w_mag;
    logic [AW-1:0]     r_piv;
    logic [AW-1:0]     r_scan_pos;
    logic              r_rd_ok;

    // forward permutation: two read ports, one write port
    logic [AW-1:0]        r_fwd [MAX_ORDER];
    logic [MAX_ORDER-1:0] r_fwd_vld;
    logic [AW-1:0]        w_fa, w_fb, w_fwa, w_fwd_wd;
    logic                 w_fre, w_fwe;
    logic [AW-1:0]        r_fa_q, r_fb_q, r_fa_idx, r_fb_idx;
    logic                 r_fa_vld, r_fb_vld;
    logic [AW-1:0]        w_fwd_a, w_fwd_b;

    // reverse permutation
    logic [AW-1:0]        r_rev [MAX_ORDER];
    logic [MAX_ORDER-1:0] r_rev_vld;
    logic                 w_rre;
    logic [AW-1:0]        r_rq, r_rq_idx;
    logic                 r_rq_vld;
    logic [AW-1:0]        w_rev_q;
    logic [AW-1:0]        r_rev_pos;

    assign w_pi     = i_pos_i[AW-1:0];
    assign w_pj     = i_pos_j[AW-1:0];
    assign w_row    = AW'(i_row);
    assign w_col    = AW'(i_col);
    assign w_row_ok = 32'(i_row) < MAX_ORDER;
    assign w_col_ok = 32'(i_col) < MAX_ORDER;

    // row phase swaps (i,j)/(p,j); column phase swaps (j,i)/(j,p)
    assign w_addr_a = i_cmd.col_phase ? {w_pj, w_pi}  : {w_pi, w_pj};
    assign w_addr_b = i_cmd.col_phase ? {w_pj, r_piv} : {r_piv, w_pj};

    always_comb begin
        w_mat_addr = w_addr_a;
        w_mat_we   = 1'b0;
        w_mat_re   = 1'b0;
        w_mat_wd   = r_mat_q;
        case (i_cmd.mat_op)
            MAT_HOST_WR: begin
                w_mat_addr = {w_row, w_col};
                w_mat_we   = w_row_ok && w_col_ok;
                w_mat_wd   = i_bits;
            end
            MAT_HOST_RD: begin
                w_mat_addr = {w_row, w_col};
                w_mat_re   = 1'b1;
            end
            MAT_DIAG_RD: begin
                w_mat_addr = {w_pj, w_pj};
                w_mat_re   = 1'b1;
            end
            MAT_SW_RD_A: begin
                w_mat_addr = w_addr_a;
                w_mat_re   = 1'b1;
            end
            MAT_SW_RD_B: begin
                w_mat_addr = w_addr_b;
                w_mat_re   = 1'b1;
            end
            MAT_SW_WR_A: begin
                w_mat_addr = w_addr_a;
                w_mat_we   = 1'b1;
                w_mat_wd   = r_mat_q;
            end
            MAT_SW_WR_B: begin
                w_mat_addr = w_addr_b;
                w_mat_we   = 1'b1;
                w_mat_wd   = r_hold;
            end
            default: begin
                w_mat_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mat_we) begin
            r_mat[w_mat_addr] <= w_mat_wd;
        end
        if (w_mat_re) begin
            r_mat_q <= r_mat[w_mat_addr];
        end
    end

    // element A is in r_mat_q while B is being read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mat_op == MAT_SW_RD_B) begin
            r_hold <= r_mat_q;
        end
    end

    // pivot search: magnitude is the pattern with the sign cleared,
    // greater-or-equal so the last of equal entries wins
    assign w_mag = r_mat_q[ELEM_W-2:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mat_op == MAT_DIAG_RD) begin
            r_scan_pos <= w_pj;
        end
        if (i_cmd.scan_init) begin
            r_best <= '0;
            r_piv  <= w_pi;
        end else if (i_cmd.scan_cmp && (r_best <= w_mag)) begin
            r_best <= w_mag;
            r_piv  <= r_scan_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mat_op == MAT_HOST_RD) begin
            r_rd_ok <= w_row_ok && w_col_ok;
        end else if (i_cmd.perm_op == PERM_HOST_RD) begin
            r_rd_ok <= w_row_ok;
        end
    end

    always_comb begin
        w_fa     = w_pi;
        w_fb     = r_piv;
        w_fre    = 1'b0;
        w_fwe    = 1'b0;
        w_fwa    = w_pi;
        w_fwd_wd = w_fwd_b;
        w_rre    = 1'b0;
        case (i_cmd.perm_op)
            PERM_HOST_RD: begin
                w_fa  = w_row;
                w_fre = 1'b1;
                w_rre = 1'b1;
            end
            PERM_SW_RD: begin
                w_fa  = w_pi;
                w_fb  = r_piv;
                w_fre = 1'b1;
            end
            PERM_SW_WR_I: begin
                w_fwe    = 1'b1;
                w_fwa    = w_pi;
                w_fwd_wd = w_fwd_b;
            end
            PERM_SW_WR_P: begin
                w_fwe    = 1'b1;
                w_fwa    = r_piv;
                w_fwd_wd = w_fwd_a;
            end
            PERM_REV_RD: begin
                w_fa  = w_pj;
                w_fre = 1'b1;
            end
            default: begin
                w_fre = 1'b0;
            end
        endcase
    end

    // an entry never written reads as its own index (identity)
    assign w_fwd_a = r_fa_vld ? r_fa_q : r_fa_idx;
    assign w_fwd_b = r_fb_vld ? r_fb_q : r_fb_idx;
    assign w_rev_q = r_rq_vld ? r_rq : r_rq_idx;

    always_ff @(posedge i_clk) begin
        if (w_fwe) begin
            r_fwd[w_fwa] <= w_fwd_wd;
        end
        if (w_fre) begin
            r_fa_q   <= r_fwd[w_fa];
            r_fa_vld <= r_fwd_vld[w_fa];
            r_fa_idx <= w_fa;
            r_fb_q   <= r_fwd[w_fb];
            r_fb_vld <= r_fwd_vld[w_fb];
            r_fb_idx <= w_fb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.perm_op == PERM_REV_RD) begin
            r_rev_pos <= w_pj;
        end
        if (i_cmd.rev_wr) begin
            r_rev[w_fwd_a] <= r_rev_pos;
        end
        if (w_rre) begin
            r_rq     <= r_rev[w_row];
            r_rq_vld <= r_rev_vld[w_row];
            r_rq_idx <= w_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= '0;
            r_rev_vld <= '0;
        end else begin
            if (w_fwe) begin
                r_fwd_vld[w_fwa] <= 1'b1;
            end
            if (i_cmd.rev_wr) begin
                r_rev_vld[w_fwd_a] <= 1'b1;
            end
        end
    end

    always_comb begin
        o_result.read_bits     = '0;
        o_result.forward_entry = '0;
        o_result.reverse_entry = '0;
        o_result.run_done      = (i_cmd.res_kind == RES_DONE);
        if (r_rd_ok && (i_cmd.res_kind == RES_MAT)) begin
            o_result.read_bits = r_mat_q;
        end
        if (r_rd_ok && (i_cmd.res_kind == RES_PERM)) begin
            o_result.forward_entry = IDX_W'(w_fwd_a);
            o_result.reverse_entry = IDX_W'(w_rev_q);
        end
    end

endmodule

### hdl/symmetric_diagonal_pivot_core.sv
`timescale 1ns / 1ps
// Top level of the symmetric diagonal pivot core: size register, response
// register, and the controller/datapath pair. Depends on sdp_pkg, sdp_if,
// sdp_ctrl and sdp_datapath.
//
//  Channel  Dir  Handshake      Carries
//  i_req    in   valid/ready    cmd, row_index, col_index, element_bits
//  o_rsp    out  valid/ready    read_bits, forward_entry, reverse_entry, run_done
//  i_cfg    in   valid/ready    matrix_size (always ready)
//
// A write request goes straight into the store; an element or permutation read
// goes through a store read, then a response register load. A run over order
// n works through the single-port matrix store: per position i a check, a
// diagonal scan, the row and column exchanges (read A, read B, write A, write
// B per element pair) and the permutation swap; then a last check and a
// rebuild of the reverse table.
// Reset (i_rst_n low at a clock edge) clears the sequencer and the permutation
// valid bits, so both tables read as identity; the matrix store is not cleared.
// Requests are taken only while the sequencer is idle. The response register
// frees the input side; a stalled sink holds the next response in its state.
module symmetric_diagonal_pivot_core #(
    parameter int MAX_ORDER = sdp_pkg::DEF_MAX_ORDER
) (
    input logic       i_clk,
    input logic       i_rst_n,
    sdp_in_if.sink    i_req,
    sdp_out_if.source o_rsp,
    sdp_cfg_if.sink   i_cfg
);
    import sdp_pkg::*;

    localparam int NW         = $clog2(MAX_ORDER + 1);
    localparam int SIZE_AT_RST = (SIZE_RESET > MAX_ORDER) ? MAX_ORDER : SIZE_RESET;

    // matrix order in use, clamped to 1..MAX_ORDER on write
    logic [NW-1:0] r_size, n_size;

    t_dp_cmd       w_dp_cmd;
    logic [NW-1:0] w_pos_i, w_pos_j;
    logic          w_req_ready;
    logic          w_out_load;
    logic          w_out_free;
    t_result       w_result;

    logic          r_out_valid;
    t_result       r_out;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (i_cfg.matrix_size == '0) begin
            n_size = NW'(1);
        end else if (32'(i_cfg.matrix_size) > MAX_ORDER) begin
            n_size = NW'(MAX_ORDER);
        end else begin
            n_size = NW'(i_cfg.matrix_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= NW'(SIZE_AT_RST);
        end else if (i_cfg.valid) begin
            r_size <= n_size;
        end
    end

    // response slot is free when empty or being drained this cycle
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_req_ready;

    sdp_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_cmd   (t_cmd'(i_req.cmd)),
        .i_size      (r_size),
        .i_out_free  (w_out_free),
        .o_req_ready (w_req_ready),
        .o_out_load  (w_out_load),
        .o_dp_cmd    (w_dp_cmd),
        .o_pos_i     (w_pos_i),
        .o_pos_j     (w_pos_j)
    );

    sdp_datapath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_dp_cmd),
        .i_pos_i  (w_pos_i),
        .i_pos_j  (w_pos_j),
        .i_row    (i_req.row_index),
        .i_col    (i_req.col_index),
        .i_bits   (i_req.element_bits),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_bits     = r_out.read_bits;
    assign o_rsp.forward_entry = r_out.forward_entry;
    assign o_rsp.reverse_entry = r_out.reverse_entry;
    assign o_rsp.run_done      = r_out.run_done;

endmodule

### test/tb_symmetric_diagonal_pivot_core.sv
`timescale 1ns / 1ps
// Self-checking bench for symmetric_diagonal_pivot_core: drives element loads,
// pivot runs and reads, and checks every response against an in-bench mirror.
// Depends on sdp_pkg, sdp_if and the core RTL.
module tb_symmetric_diagonal_pivot_core;
    import sdp_pkg::*;

    localparam int ORDER_MAX  = DEF_MAX_ORDER;
    localparam int IDLE_PCT   = 19;       // idle / stall odds per cycle, in percent
    localparam int STALL_MAX  = 40000;    // cycles with no handshake before giving up
    localparam int ITEM_GOAL  = 1050;
    localparam int SETTLE_CYC = 4;        // lets a trailing write or read finish

    logic i_clk;
    logic i_rst_n;

    sdp_in_if  req_if ();
    sdp_out_if rsp_if ();
    sdp_cfg_if cfg_if ();

    symmetric_diagonal_pivot_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Mirror of the core state. Matrix words are raw double bit patterns;
    // the written map keeps reads (and runs) on cells that hold real data.
    // ------------------------------------------------------------------
    logic [ELEM_W-1:0] elem_mirror [ORDER_MAX][ORDER_MAX];
    bit                elem_loaded [ORDER_MAX][ORDER_MAX];
    int                loaded_cells[$];          // row * ORDER_MAX + col
    logic [IDX_W-1:0]  fwd_mirror  [ORDER_MAX];
    logic [IDX_W-1:0]  rev_mirror  [ORDER_MAX];
    int                order_mirror;

    t_result           pending_results[$];       // responses owed, oldest first

    bit                quiet_mode;               // no idling on either side
    bit                req_raised;               // our own copy of req valid
    logic [ELEM_W-1:0] last_element;
    int                mismatches;
    int                requests_sent;
    int                results_checked;
    int                runs_sent;
    int                size_settings;
    int                stall_count;

    // Size register semantics: 0 reads as 1, anything above the store order
    // saturates to it.
    function automatic int clamp_order(input logic [SIZE_W-1:0] value);
        if (value == '0) return 1;
        if (int'(value) > ORDER_MAX) return ORDER_MAX;
        return int'(value);
    endfunction

    // Pivot over the leading order_mirror block. Magnitude is the pattern with
    // the sign cleared, so NaNs sort above infinities; ">=" on the running
    // maximum means the last of equal magnitudes wins.
    function automatic void pivot_mirror();
        int                n;
        int                p;
        logic [ELEM_W-1:0] best;
        logic [ELEM_W-1:0] mag;
        logic [ELEM_W-1:0] tmp;
        logic [IDX_W-1:0]  t;
        n = order_mirror;
        for (int i = 0; i + 1 < n; i++) begin
            best = '0;
            p    = i;
            for (int j = i; j < n; j++) begin
                mag = {1'b0, elem_mirror[j][j][ELEM_W-2:0]};
                if (best <= mag) begin
                    best = mag;
                    p    = j;
                end
            end
            for (int j = 0; j < n; j++) begin
                tmp               = elem_mirror[p][j];
                elem_mirror[p][j] = elem_mirror[i][j];
                elem_mirror[i][j] = tmp;
            end
            for (int j = 0; j < n; j++) begin
                tmp               = elem_mirror[j][p];
                elem_mirror[j][p] = elem_mirror[j][i];
                elem_mirror[j][i] = tmp;
            end
            t             = fwd_mirror[i];
            fwd_mirror[i] = fwd_mirror[p];
            fwd_mirror[p] = t;
        end
        for (int i = 0; i < n; i++)
            rev_mirror[fwd_mirror[i]] = IDX_W'(i);
    endfunction

    // A run reads the whole active block, so it is only legal once every cell
    // of that block holds written data.
    function automatic bit block_loaded(input int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                if (!elem_loaded[r][c]) return 1'b0;
        return 1'b1;
    endfunction

    // Mix of plain random doubles and the awkward patterns: signed zeros,
    // infinities, NaNs, the field extremes, and sign-flipped repeats for ties.
    function automatic logic [ELEM_W-1:0] pick_element();
        logic [ELEM_W-1:0] v;
        case ($urandom_range(11))
            0:       v = 64'h0000_0000_0000_0000;
            1:       v = 64'h8000_0000_0000_0000;
            2:       v = 64'h7FF0_0000_0000_0000;
            3:       v = 64'hFFF0_0000_0000_0000;
            4:       v = 64'h7FF8_0000_0000_0000;
            5:       v = 64'hFFFF_FFFF_FFFF_FFFF;
            6:       v = 64'h7FFF_FFFF_FFFF_FFFF;
            7:       v = last_element ^ 64'h8000_0000_0000_0000;
            default: v = {$urandom, $urandom};
        endcase
        last_element = v;
        return v;
    endfunction

    function automatic void check_field(input string name, input logic [ELEM_W-1:0] want,
                                        input logic [ELEM_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: one request per call, random idle cycles ahead of it (with a
    // scrambled payload while valid is low). Valid is left high on accept so
    // back-to-back requests never lower and raise it in the same step.
    // ------------------------------------------------------------------
    task automatic send_request(input t_cmd op, input logic [IDX_W-1:0] row,
                                input logic [IDX_W-1:0] col, input logic [ELEM_W-1:0] bits);
        t_result outcome;
        while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
            if (req_raised) begin
                req_if.valid <= 1'b0;
                req_raised = 1'b0;
            end
            req_if.cmd          <= CMD_W'($urandom_range(3));
            req_if.row_index    <= IDX_W'($urandom);
            req_if.col_index    <= IDX_W'($urandom);
            req_if.element_bits <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_raised = 1'b1;
        req_if.cmd          <= op;
        req_if.row_index    <= row;
        req_if.col_index    <= col;
        req_if.element_bits <= bits;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);

        // accepted at this edge: advance the mirror and queue what is owed
        requests_sent++;
        outcome = '0;
        case (op)
            CMD_WRITE: begin
                elem_mirror[row][col] = bits;
                if (!elem_loaded[row][col]) begin
                    elem_loaded[row][col] = 1'b1;
                    loaded_cells.push_back(int'(row) * ORDER_MAX + int'(col));
                end
            end
            CMD_RUN: begin
                pivot_mirror();
                runs_sent++;
                outcome.run_done = 1'b1;
                pending_results.push_back(outcome);
            end
            CMD_READ_EL: begin
                outcome.read_bits = elem_mirror[row][col];
                pending_results.push_back(outcome);
            end
            CMD_READ_PERM: begin
                outcome.forward_entry = fwd_mirror[row];
                outcome.reverse_entry = rev_mirror[row];
                pending_results.push_back(outcome);
            end
        endcase
    endtask

    // Sender holds off until every owed response is back.
    task automatic drain_results();
        if (req_raised) begin
            req_if.valid <= 1'b0;
            req_raised = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Size writes only while the core is idle. Writes produce no response, so
    // a settling wait covers one that may still be finishing.
    task automatic set_order(input logic [SIZE_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.matrix_size <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        order_mirror = clamp_order(value);
        size_settings++;
    endtask

    task automatic read_random_loaded();
        int idx;
        idx = loaded_cells[$urandom_range(loaded_cells.size() - 1)];
        send_request(CMD_READ_EL, IDX_W'(idx / ORDER_MAX), IDX_W'(idx % ORDER_MAX), '0);
    endtask

    // Symmetric fill of the active block.
    task automatic load_block(input int n);
        logic [ELEM_W-1:0] v;
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= r; c++) begin
                v = pick_element();
                send_request(CMD_WRITE, IDX_W'(r), IDX_W'(c), v);
                if (c != r) send_request(CMD_WRITE, IDX_W'(c), IDX_W'(r), v);
            end
    endtask

    // ------------------------------------------------------------------
    // Receiver and response checker. Ready stalls at random; each accepted
    // response is matched against the oldest owed one, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        rsp_if.ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t ns: response with none owed: read_bits %h fwd %0d rev %0d done %b",
                         $time, rsp_if.read_bits, rsp_if.forward_entry,
                         rsp_if.reverse_entry, rsp_if.run_done);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("read_bits", want.read_bits, rsp_if.read_bits);
                check_field("forward_entry", ELEM_W'(want.forward_entry),
                            ELEM_W'(rsp_if.forward_entry));
                check_field("reverse_entry", ELEM_W'(want.reverse_entry),
                            ELEM_W'(rsp_if.reverse_entry));
                check_field("run_done", ELEM_W'(want.run_done), ELEM_W'(rsp_if.run_done));
            end
        end
    end

    // Watchdog: the limit sits far above the longest run at the largest order
    // used here, so it only trips on a real hang.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !i_rst_n)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count == STALL_MAX) begin
            $display("%0t ns: no handshake for %0d cycles, %0d responses owed",
                     $time, STALL_MAX, pending_results.size());
            $display("symmetric_diagonal_pivot_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Tables read as identity out of reset; element field extremes at the
    // corners of the store with the reset order of 64.
    task automatic test_reset_tables();
        send_request(CMD_READ_PERM, 6'd0, 6'd0, '0);
        send_request(CMD_READ_PERM, 6'd63, 6'd0, '0);
        send_request(CMD_WRITE, 6'd0, 6'd0, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(CMD_WRITE, 6'd63, 6'd63, 64'h8000_0000_0000_0000);
        send_request(CMD_WRITE, 6'd0, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_READ_EL, 6'd0, 6'd0, '0);
        send_request(CMD_READ_EL, 6'd63, 6'd63, '0);
        send_request(CMD_READ_EL, 6'd0, 6'd63, '0);
    endtask

    // Order 3: a negative zero against a NaN and a negative NaN of equal
    // magnitude, so the scan must rank NaN highest and break the tie to the
    // later index.
    task automatic test_tie_and_nan_pivot();
        set_order(7'd3);
        send_request(CMD_WRITE, 6'd0, 6'd0, 64'h8000_0000_0000_0000);
        send_request(CMD_WRITE, 6'd1, 6'd1, 64'h7FF8_0000_0000_0000);
        send_request(CMD_WRITE, 6'd2, 6'd2, 64'hFFF8_0000_0000_0000);
        send_request(CMD_WRITE, 6'd0, 6'd1, 64'h3FF0_0000_0000_0000);
        send_request(CMD_WRITE, 6'd1, 6'd0, 64'h3FF0_0000_0000_0000);
        send_request(CMD_WRITE, 6'd0, 6'd2, 64'hC000_0000_0000_0000);
        send_request(CMD_WRITE, 6'd2, 6'd0, 64'hC000_0000_0000_0000);
        send_request(CMD_WRITE, 6'd1, 6'd2, 64'h4008_0000_0000_0000);
        send_request(CMD_WRITE, 6'd2, 6'd1, 64'h4008_0000_0000_0000);
        send_request(CMD_RUN, 6'd0, 6'd0, '0);
        for (int k = 0; k < 3; k++)
            send_request(CMD_READ_PERM, IDX_W'(k), 6'd0, '0);
        send_request(CMD_READ_EL, 6'd0, 6'd0, '0);
        send_request(CMD_READ_EL, 6'd2, 6'd1, '0);
    endtask

    // Size register extremes: 0 acts as 1 (a run that only rebuilds the
    // reverse entry), a value past the store order saturates to 64.
    task automatic test_size_limits();
        set_order(7'd0);
        send_request(CMD_RUN, 6'd0, 6'd0, '0);
        send_request(CMD_READ_PERM, 6'd0, 6'd0, '0);
        set_order(7'd127);
        send_request(CMD_WRITE, 6'd63, 6'd0, 64'h0000_0000_0000_0001);
        send_request(CMD_READ_EL, 6'd63, 6'd0, '0);
        send_request(CMD_READ_PERM, 6'd63, 6'd0, '0);
        set_order(7'd64);
    endtask

    // Random phases: pick an order, load its block (or keep the old contents
    // so runs compose), then a random mix of loads, reads and runs.
    task automatic test_random_phases();
        int phase;
        int n;
        int ops;
        int sel;
        int big_left;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        phase    = 0;
        big_left = 2;
        while (requests_sent < ITEM_GOAL) begin
            phase++;
            sel = $urandom_range(99);
            if (sel < 8)
                n = 1;
            else if (sel < 14 && big_left > 0) begin
                n = $urandom_range(12, 16);
                big_left--;
            end else
                n = $urandom_range(2, 8);
            set_order(SIZE_W'(n));
            quiet_mode = (phase == 5);       // one long stretch without idling
            if (!block_loaded(n) || $urandom_range(3) == 0)
                load_block(n);
            ops = $urandom_range(20, 50);
            for (int k = 0; k < ops; k++) begin
                if (phase == 3 && k == ops / 2)
                    drain_results();         // sender waits out every response once
                sel = $urandom_range(99);
                if (sel < 30) begin
                    if ($urandom_range(4) != 0) begin
                        row = IDX_W'($urandom_range(n - 1));
                        col = IDX_W'($urandom_range(n - 1));
                    end else begin
                        row = IDX_W'($urandom);
                        col = IDX_W'($urandom);
                    end
                    send_request(CMD_WRITE, row, col, pick_element());
                end else if (sel < 65) begin
                    read_random_loaded();
                end else if (sel < 90) begin
                    row = ($urandom_range(1) == 0) ? IDX_W'($urandom_range(n - 1))
                                                   : IDX_W'($urandom);
                    send_request(CMD_READ_PERM, row, IDX_W'($urandom), '0);
                end else if (block_loaded(n)) begin
                    send_request(CMD_RUN, IDX_W'($urandom), IDX_W'($urandom), {$urandom, $urandom});
                    repeat ($urandom_range(2))
                        send_request(CMD_READ_PERM, IDX_W'($urandom_range(n - 1)), '0, '0);
                end else begin
                    read_random_loaded();
                end
            end
            quiet_mode = 1'b0;
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.cmd          = CMD_WRITE;
        req_if.row_index    = '0;
        req_if.col_index    = '0;
        req_if.element_bits = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.matrix_size  = SIZE_W'(SIZE_RESET);
        quiet_mode          = 1'b0;
        req_raised          = 1'b0;
        last_element        = '0;
        mismatches          = 0;
        requests_sent       = 0;
        results_checked     = 0;
        runs_sent           = 0;
        size_settings       = 0;
        order_mirror        = SIZE_RESET;
        for (int k = 0; k < ORDER_MAX; k++) begin
            fwd_mirror[k] = IDX_W'(k);
            rev_mirror[k] = IDX_W'(k);
            for (int c = 0; c < ORDER_MAX; c++) begin
                elem_mirror[k][c] = '0;
                elem_loaded[k][c] = 1'b0;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_tables();
        test_tie_and_nan_pivot();
        test_size_limits();
        test_random_phases();

        drain_results();
        repeat (20) @(posedge i_clk);  // catch any stray response

        $display("Ran %0d requests including %0d pivot runs over %0d size settings;",
                 requests_sent, runs_sent, size_settings);
        $display("%0d responses compared, %0d field errors.", results_checked, mismatches);
        if (mismatches == 0)
            $display("symmetric_diagonal_pivot_core: match");
        else
            $display("symmetric_diagonal_pivot_core: mismatch");
        $finish;
    end

endmodule
